// ===== hdl/incremental_pid_heading_macros.svh =====
// assertion macros for the incremental pid heading block
`ifndef INCREMENTAL_PID_HEADING_MACROS_SVH
`define INCREMENTAL_PID_HEADING_MACROS_SVH

`ifndef SYNTHESIS
`define IPH_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("iph assertion failed");
`define IPH_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);
`else
`define IPH_ASSERT(lbl, clk, rstn, prop)
`define IPH_ASSERT_MSG(lbl, clk, rstn, prop, msg)
`endif

`endif

// ===== hdl/iph_pkg.sv =====
package iph_pkg;

	localparam int GAIN_W  = 24;
	localparam int LIMIT_W = 15;
	localparam int DATA_W  = 16;
	localparam int ERR_W   = 17;
	localparam int ADDR_W  = 4;
	localparam int APB_W   = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd2458;

	typedef enum logic [1:0] {
		REG_PROP  = 2'd0,
		REG_INTEG = 2'd1,
		REG_DERIV = 2'd2,
		REG_LIMIT = 2'd3
	} iph_reg_e_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integral_gain;
		logic [GAIN_W-1:0]  derivative_gain;
		logic [LIMIT_W-1:0] output_limit;
	} iph_cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]  last_error;
		logic signed [ERR_W-1:0]  older_error;
		logic signed [DATA_W-1:0] last_drive;
	} iph_state_t;

endpackage

// ===== hdl/iph_regs.sv =====
module iph_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [iph_pkg::ADDR_W-1:0] paddr,
	input  logic [iph_pkg::APB_W-1:0]  pwdata,
	output logic [iph_pkg::APB_W-1:0]  prdata,
	output logic                       pready,
	output iph_pkg::iph_cfg_t          cfg
);
	import iph_pkg::*;

	iph_cfg_t   cfg_q;
	iph_reg_e_t sel;
	logic       wr_en;

	assign sel    = iph_reg_e_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain       <= '0;
			cfg_q.integral_gain   <= '0;
			cfg_q.derivative_gain <= '0;
			cfg_q.output_limit    <= LIMIT_RESET;
		end else if (wr_en) begin
			unique case (sel)
				REG_PROP:  cfg_q.prop_gain       <= pwdata[GAIN_W-1:0];
				REG_INTEG: cfg_q.integral_gain   <= pwdata[GAIN_W-1:0];
				REG_DERIV: cfg_q.derivative_gain <= pwdata[GAIN_W-1:0];
				REG_LIMIT: cfg_q.output_limit    <= pwdata[LIMIT_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (sel)
			REG_PROP:  prdata = {{(APB_W-GAIN_W){1'b0}}, cfg_q.prop_gain};
			REG_INTEG: prdata = {{(APB_W-GAIN_W){1'b0}}, cfg_q.integral_gain};
			REG_DERIV: prdata = {{(APB_W-GAIN_W){1'b0}}, cfg_q.derivative_gain};
			REG_LIMIT: prdata = {{(APB_W-LIMIT_W){1'b0}}, cfg_q.output_limit};
			default:   prdata = '0;
		endcase
	end

endmodule

// ===== hdl/iph_core.sv =====
module iph_core (
	input  logic                              kind,
	input  logic signed [iph_pkg::DATA_W-1:0] setpoint,
	input  logic signed [iph_pkg::DATA_W-1:0] feedback,
	input  iph_pkg::iph_cfg_t                 cfg,
	input  iph_pkg::iph_state_t               cur,
	output iph_pkg::iph_state_t               nxt
);
	import iph_pkg::*;

	localparam int SUM_W = 47;

	logic signed [ERR_W-1:0] err;
	logic signed [17:0]      d_p;
	logic signed [17:0]      d_i;
	logic signed [18:0]      d_d;
	logic signed [42:0]      prod_p;
	logic signed [42:0]      prod_i;
	logic signed [43:0]      prod_d;
	logic signed [31:0]      drv_al;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] lim;
	logic signed [SUM_W-1:0] neg_lim;
	logic signed [SUM_W-1:0] rounded;
	logic signed [DATA_W-1:0] lim16;
	logic signed [DATA_W-1:0] drive;

	assign err = $signed({setpoint[DATA_W-1], setpoint}) -
		$signed({feedback[DATA_W-1], feedback});

	assign d_p = 18'(err) - 18'(cur.last_error);
	assign d_i = 18'(err) + 18'(cur.last_error);
	assign d_d = 19'(err) - (19'(cur.last_error) <<< 1) + 19'(cur.older_error);

	assign prod_p = 43'(d_p) * 43'($signed({1'b0, cfg.prop_gain}));
	assign prod_i = 43'(d_i) * 43'($signed({1'b0, cfg.integral_gain}));
	assign prod_d = 44'(d_d) * 44'($signed({1'b0, cfg.derivative_gain}));

	assign drv_al  = $signed({cur.last_drive, 16'b0});
	assign sum     = SUM_W'(drv_al) + SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
	assign lim     = $signed({16'b0, cfg.output_limit, 16'b0});
	assign neg_lim = -lim;
	assign rounded = sum + SUM_W'(32768);
	assign lim16   = $signed({1'b0, cfg.output_limit});

	always_comb begin
		if (sum > lim) begin
			drive = lim16;
		end else if (sum < neg_lim) begin
			drive = -lim16;
		end else begin
			drive = rounded[31:16];
		end
	end

	always_comb begin
		if (kind) begin
			nxt = '0;
		end else begin
			nxt.last_error  = err;
			nxt.older_error = cur.last_error;
			nxt.last_drive  = drive;
		end
	end

endmodule

// ===== hdl/incremental_pid_heading.sv =====
// channel  | direction | handshake            | payload
// update   | in        | upd_valid, upd_stall | kind, setpoint, feedback
// result   | out       | res_valid, res_stall | drive
// config   | in        | apb write/read       | gains, output limit
//
// one beat in, one beat out; an accepted beat waits in the input register, then
// passes the core into the result register; with res_stall low the sustained rate
// is one beat per cycle, set by the combinational multiply and clamp
// arst_n clears valid flags, history and registers; output limit resets to 0.6
// a stalled result holds; the input register still fills, then upd_stall rises
`include "incremental_pid_heading_macros.svh"

module incremental_pid_heading (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              upd_valid,
	output logic                              upd_stall,
	input  logic                              kind,
	input  logic signed [iph_pkg::DATA_W-1:0] setpoint,
	input  logic signed [iph_pkg::DATA_W-1:0] feedback,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic signed [iph_pkg::DATA_W-1:0] drive,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [iph_pkg::ADDR_W-1:0]        paddr,
	input  logic [iph_pkg::APB_W-1:0]         pwdata,
	output logic [iph_pkg::APB_W-1:0]         prdata,
	output logic                              pready
);
	import iph_pkg::*;

	iph_cfg_t   cfg;
	iph_state_t state_q;
	iph_state_t state_nxt;

	logic                     valid_s1;
	logic                     kind_s1;
	logic signed [DATA_W-1:0] setpoint_s1;
	logic signed [DATA_W-1:0] feedback_s1;
	logic                     res_valid_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     out_free;
	logic                     adv;
	logic                     accept;

	iph_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	iph_core u_core (
		.kind     (kind_s1),
		.setpoint (setpoint_s1),
		.feedback (feedback_s1),
		.cfg      (cfg),
		.cur      (state_q),
		.nxt      (state_nxt)
	);

	assign out_free  = !res_valid_q || !res_stall;
	assign adv       = valid_s1 && out_free;
	assign upd_stall = valid_s1 && !out_free;
	assign accept    = upd_valid && !upd_stall;
	assign res_valid = res_valid_q;
	assign drive     = drive_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind;
			setpoint_s1 <= setpoint;
			feedback_s1 <= feedback;
		end
	end

	// controller history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q <= state_nxt.last_drive;
		end
	end

	`IPH_ASSERT(a_stall_needs_s1, clk, arst_n, upd_stall |-> valid_s1)
	`IPH_ASSERT(a_s1_holds, clk, arst_n, (valid_s1 && !out_free) |=> valid_s1)
	`IPH_ASSERT_MSG(a_clear_zeroes, clk, arst_n,
		(adv && kind_s1) |=> (state_q == '0 && drive_q == '0), "clear left history")
	`IPH_ASSERT_MSG(a_drive_tracks, clk, arst_n,
		res_valid_q |-> (state_q.last_drive == drive_q), "drive and history differ")

endmodule

// ===== tb/sv/pid_tb_pkg.sv =====
`timescale 1ns / 1ps

package pid_tb_pkg;

	typedef enum logic {
		KIND_UPDATE = 1'b0,
		KIND_CLEAR  = 1'b1
	} upd_kind_e;

endpackage

// ===== tb/sv/pid_drive_check.sv =====
`timescale 1ns / 1ps

module pid_drive_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              upd_valid,
	input  logic                              upd_stall,
	input  logic                              kind,
	input  logic signed [iph_pkg::DATA_W-1:0] setpoint,
	input  logic signed [iph_pkg::DATA_W-1:0] feedback,
	input  logic                              res_valid,
	input  logic                              res_stall,
	input  logic signed [iph_pkg::DATA_W-1:0] drive,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic                              pready,
	input  logic [iph_pkg::ADDR_W-1:0]        paddr,
	input  logic [iph_pkg::APB_W-1:0]         pwdata,
	output int                                mismatches,
	output int                                pending,
	output int                                checked
);
	import iph_pkg::*;
	import pid_tb_pkg::*;

	longint kp, ki, kd, limit;
	longint err1, err2, prev_drive;
	logic signed [DATA_W-1:0] drive_due[$];

	// velocity-form update: sum in q.28, clamp, round half up to q4.12
	task automatic predict_drive(input logic k, input logic signed [DATA_W-1:0] sp,
			input logic signed [DATA_W-1:0] fb);
		longint err, sum, lim, res;
		if (k == KIND_CLEAR) begin
			err1 = 0;
			err2 = 0;
			prev_drive = 0;
			drive_due.push_back('0);
		end else begin
			err = longint'(sp) - longint'(fb);
			sum = prev_drive * 65536 + (err - err1) * kp + (err + err1) * ki
				+ (err - 2 * err1 + err2) * kd;
			lim = limit * 65536;
			if (sum > lim)
				res = limit;
			else if (sum < -lim)
				res = -limit;
			else
				res = (sum + 32768) >>> 16;
			err2 = err1;
			err1 = err;
			prev_drive = res;
			drive_due.push_back(res[DATA_W-1:0]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = 0;
			ki = 0;
			kd = 0;
			limit = longint'(LIMIT_RESET);
			err1 = 0;
			err2 = 0;
			prev_drive = 0;
			drive_due.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (iph_reg_e_t'(paddr[ADDR_W-1:2]))
					REG_PROP:  kp = longint'(pwdata[GAIN_W-1:0]);
					REG_INTEG: ki = longint'(pwdata[GAIN_W-1:0]);
					REG_DERIV: kd = longint'(pwdata[GAIN_W-1:0]);
					REG_LIMIT: limit = longint'(pwdata[LIMIT_W-1:0]);
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (drive_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected drive beat %0d", $time, drive);
				end else begin
					checked++;
					if (drive !== drive_due[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: drive mismatch, expected %0d got %0d",
								$time, drive_due[0], drive);
					end
					void'(drive_due.pop_front());
				end
			end
			if (upd_valid && !upd_stall)
				predict_drive(kind, setpoint, feedback);
			pending <= drive_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import iph_pkg::*;
	import pid_tb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BEATS = 230;

	logic                     clk;
	logic                     arst_n;
	logic                     upd_valid;
	logic                     upd_stall;
	logic                     kind;
	logic signed [DATA_W-1:0] setpoint;
	logic signed [DATA_W-1:0] feedback;
	logic                     res_valid;
	logic                     res_stall;
	logic signed [DATA_W-1:0] drive;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_W-1:0]        paddr;
	logic [APB_W-1:0]         pwdata;
	logic [APB_W-1:0]         prdata;
	logic                     pready;

	int mismatches, pending, checked;
	int send_idle_pct, stall_pct;
	int hold_request, hold_left, long_holds;
	int beats_sent, clears_sent, settings_loaded;
	int cycle_count;

	incremental_pid_heading u_top (
		.clk(clk), .arst_n(arst_n),
		.upd_valid(upd_valid), .upd_stall(upd_stall),
		.kind(kind), .setpoint(setpoint), .feedback(feedback),
		.res_valid(res_valid), .res_stall(res_stall), .drive(drive),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pid_drive_check u_check (
		.clk(clk), .arst_n(arst_n),
		.upd_valid(upd_valid), .upd_stall(upd_stall),
		.kind(kind), .setpoint(setpoint), .feedback(feedback),
		.res_valid(res_valid), .res_stall(res_stall), .drive(drive),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.mismatches(mismatches), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// result side: random stall, or one long hold-off when asked
	initial begin
		res_stall = 1'b0;
		hold_left = 0;
		long_holds = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_request = 0;
				hold_left = 300;
				long_holds++;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic send_beat(input upd_kind_e k, input logic signed [DATA_W-1:0] sp,
			input logic signed [DATA_W-1:0] fb);
		upd_valid <= 1'b1;
		kind <= k;
		setpoint <= sp;
		feedback <= fb;
		do @(posedge clk); while (upd_stall);
		beats_sent++;
		if (k == KIND_CLEAR)
			clears_sent++;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			upd_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic reg_write(input iph_reg_e_t r, input logic [APB_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// only while nothing is in flight
	task automatic load_settings(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
			input logic [GAIN_W-1:0] d, input logic [LIMIT_W-1:0] l);
		upd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		reg_write(REG_PROP, APB_W'(p));
		reg_write(REG_INTEG, APB_W'(i));
		reg_write(REG_DERIV, APB_W'(d));
		reg_write(REG_LIMIT, APB_W'(l));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_loaded++;
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		if ($urandom_range(0, 3) == 0)
			return GAIN_W'($urandom);
		return GAIN_W'($urandom_range(0, 24'h03FFFF));
	endfunction

	task automatic random_beat();
		int pick;
		logic signed [DATA_W-1:0] sp, fb;
		pick = $urandom_range(0, 99);
		sp = DATA_W'($urandom);
		fb = DATA_W'($urandom);
		if (pick < 8)
			send_beat(KIND_CLEAR, sp, fb);
		else if (pick < 40)
			send_beat(KIND_UPDATE, sp, fb);
		else
			send_beat(KIND_UPDATE, sp, sp + DATA_W'($urandom_range(0, 1023)) - 16'sd512);
	endtask

	initial begin
		arst_n = 1'b0;
		upd_valid = 1'b0;
		kind = KIND_UPDATE;
		setpoint = '0;
		feedback = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		beats_sent = 0;
		clears_sent = 0;
		settings_loaded = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rounding ties in both directions
		load_settings(24'h008000, 24'h0, 24'h0, 15'h7FFF);
		send_beat(KIND_UPDATE, 16'sd1, 16'sd0);
		send_beat(KIND_UPDATE, 16'sd0, 16'sd0);
		send_beat(KIND_UPDATE, 16'sd0, 16'sd1);
		send_beat(KIND_UPDATE, -16'sd1, 16'sd0);
		send_beat(KIND_UPDATE, 16'sd0, -16'sd1);
		send_beat(KIND_CLEAR, 16'sh7FFF, -16'sh8000);
		send_beat(KIND_UPDATE, 16'sh7FFF, -16'sh8000);
		send_beat(KIND_UPDATE, -16'sh8000, 16'sh7FFF);

		// saturate both ways
		load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF);
		send_beat(KIND_UPDATE, 16'sh7FFF, -16'sh8000);
		send_beat(KIND_UPDATE, 16'sh7FFF, 16'sh7FFF);
		send_beat(KIND_UPDATE, -16'sh8000, 16'sh7FFF);
		send_beat(KIND_UPDATE, -16'sh8000, -16'sh8000);
		send_beat(KIND_CLEAR, -16'sh8000, 16'sh7FFF);
		send_beat(KIND_UPDATE, 16'sd0, 16'sd0);

		// zero limit
		load_settings(24'h010000, 24'h004000, 24'h002000, 15'd0);
		send_beat(KIND_UPDATE, 16'sh1000, 16'sd0);
		send_beat(KIND_UPDATE, -16'sh1000, 16'sd0);
		send_beat(KIND_UPDATE, 16'sh7FFF, -16'sh8000);
		send_beat(KIND_CLEAR, 16'sd0, 16'sd0);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_settings(24'h010000, 24'h000800, 24'h000400, LIMIT_RESET);
				1: load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF);
				2: load_settings(24'h0, 24'h0, 24'h0, 15'd0);
				default: load_settings(pick_gain(), pick_gain(), pick_gain(),
					($urandom_range(0, 3) == 0) ? 15'h7FFF : LIMIT_W'($urandom));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 29; stall_pct = 29; end
			endcase
			// block fills up while the result side holds off
			if (ph == 4)
				hold_request = 1;
			for (int n = 0; n < PHASE_BEATS; n++)
				random_beat();
		end

		upd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d update beats (%0d clears) under %0d gain and limit settings",
			beats_sent, clears_sent, settings_loaded);
		$display("compared %0d drive beats, with %0d long result hold-off",
			checked, long_holds);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
